>>> hw/rtl/imu_heater_temperature_controller_core_assert.svh
// Assertion macros for the heater controller core; clk and arst_n come from the using scope.
`ifndef IMU_HEATER_TEMPERATURE_CONTROLLER_CORE_ASSERT_SVH
`define IMU_HEATER_TEMPERATURE_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define IMUHTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IMUHTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/imuhtc_pkg.sv
// Shared types, widths and constants of the heater controller core.
`timescale 1ns / 1ps
`default_nettype none
package imuhtc_pkg;

	localparam int TEMP_W     = 16;
	localparam int TGT_W      = 8;
	localparam int TS_W       = 32;
	localparam int PWM_W      = 16;
	localparam int OUT_W      = 24;
	localparam int BAND_W     = 12;
	localparam int INTEG_W    = 16;
	localparam int DT_W       = 8;
	localparam int ERR_W      = 18;
	localparam int PROD_W     = ERR_W + PWM_W + 1;
	localparam int Y_W        = 27;
	localparam int MAG_W      = 25;
	localparam int DIV_SHIFT  = 29;
	localparam int MAGIC_W    = 23;
	localparam int QP_W       = MAG_W - 3 + MAGIC_W;
	localparam int Q_W        = 16;
	localparam int STEP_W     = 17;
	localparam int P_W        = 22;
	localparam int O1_W       = PROD_W - 8;
	localparam int C_W        = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_BAND = 3'd4;

	localparam logic [TS_W-1:0]   PERIOD_MS = 32'd100;
	localparam logic [TS_W-1:0]   DT_CAP_MS = 32'd200;
	localparam logic [DT_W-1:0]   DT_CAP    = 8'd200;
	localparam logic [TS_W-1:0]   WINDOW_MS = 32'd2000;
	localparam logic [PWM_W-1:0]  LIMIT_CAP = 16'd200;

	localparam logic signed [TEMP_W-1:0] TEMP_LOW_Q     = -16'sd10240;
	localparam logic signed [TEMP_W-1:0] TEMP_HIGH_Q    = 16'sd15360;
	localparam logic signed [TEMP_W-1:0] WIN_LOW_RESET  = 16'sd25600;
	localparam logic signed [TEMP_W-1:0] WIN_HIGH_RESET = -16'sd25600;
	localparam logic signed [TEMP_W:0]   SWING_Q        = 17'sd128;
	localparam logic signed [ERR_W-1:0]  OVERHEAT_ERR   = -18'sd256;
	localparam logic signed [Y_W-1:0]    ROUND_HALF     = 27'sd500;
	localparam logic signed [Y_W-1:0]    ROUND_UP       = 27'sd999;
	// ceil(2^29 / 125): exact floor division by 125 for 22-bit operands
	localparam logic [MAGIC_W-1:0]       DIV_MAGIC      = 23'd4294968;

	localparam logic [0:0]               MODE_RESET   = 1'b0;
	localparam logic signed [TGT_W-1:0]  TARGET_RESET = 8'sd40;
	localparam logic [PWM_W-1:0]         PWM_RESET    = 16'd200;
	localparam logic [PWM_W-1:0]         GAIN_RESET   = 16'd2560;
	localparam logic [BAND_W-1:0]        BAND_RESET   = 12'd256;

	typedef enum logic [2:0] {
		CLS_OFF,
		CLS_BAD,
		CLS_HOLD,
		CLS_RUN0,
		CLS_RUN1
	} cls_t;

	typedef struct packed {
		logic                     mode;
		logic signed [TGT_W-1:0]  target_temp;
		logic [PWM_W-1:0]         pwm_max;
		logic [PWM_W-1:0]         prop_gain;
		logic [BAND_W-1:0]        stable_band;
	} cfg_t;

	typedef struct packed {
		cls_t                     cls;
		logic signed [ERR_W-1:0]  err;
		logic signed [PROD_W-1:0] prod;
		logic                     stable;
	} s2_t;

	typedef struct packed {
		cls_t                     cls;
		logic signed [STEP_W-1:0] step;
		logic signed [P_W-1:0]    p;
		logic [OUT_W-1:0]         o1;
		logic                     err_le0;
		logic                     ovh;
		logic                     stable;
	} s3_t;

endpackage
`default_nettype wire

>>> hw/rtl/imuhtc_in_if.sv
// Sample channel: valid/ready plus one temperature sample with flags.
`timescale 1ns / 1ps
`default_nettype none
interface imuhtc_in_if;
	import imuhtc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temp;
	logic                     temp_valid;
	logic [TS_W-1:0]          now_ms;
	logic                     store_busy;
	logic                     heat_enable;

	modport source (
		output valid, temp, temp_valid, now_ms, store_busy, heat_enable,
		input  ready
	);
	modport sink (
		input  valid, temp, temp_valid, now_ms, store_busy, heat_enable,
		output ready
	);
endinterface
`default_nettype wire

>>> hw/rtl/imuhtc_out_if.sv
// Result channel: valid/ready plus heater PWM, controller output and stable flag.
`timescale 1ns / 1ps
`default_nettype none
interface imuhtc_out_if;
	import imuhtc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PWM_W-1:0] pwm;
	logic [OUT_W-1:0] ctrl_out;
	logic             stable;

	modport source (
		output valid, pwm, ctrl_out, stable,
		input  ready
	);
	modport sink (
		input  valid, pwm, ctrl_out, stable,
		output ready
	);
endinterface
`default_nettype wire

>>> hw/rtl/imu_heater_temperature_controller_core.sv
// Top level of the heater temperature controller: config, three work stages and result register.
//
//   channel   kind        handshake        contents
//   sample    in  item    valid/ready      temp, temp_valid, now_ms, store_busy, heat_enable
//   result    out item    valid/ready      pwm, ctrl_out, stable
//   cfg       in  write   cfg_we           cfg_idx, cfg_data
//
// One item per cycle unless the result stalls; items pass the input, s2, s3 and result registers.
// The stage boundaries sit at the two multipliers (err times gain or dt, and the
// reciprocal for the divide by 1000); the integrator loop closes in the last stage.
// Reset clears config to defaults, all valid bits, timers, window and held outputs.
// A stalled result holds; earlier stages keep filling, so input ready drops only
// when all four stages are full.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_heater_temperature_controller_core_assert.svh"
module imu_heater_temperature_controller_core (
	input  logic                               clk,
	input  logic                               arst_n,
	imuhtc_in_if.sink                          sample,
	imuhtc_out_if.source                       result,
	input  logic                               cfg_we,
	input  logic [imuhtc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [imuhtc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import imuhtc_pkg::*;

	cfg_t       cfg;
	logic       vld_s2;
	s2_t        pay_s2;
	logic       s2_take;
	logic       vld_s3;
	s3_t        pay_s3;
	logic       s3_take;
	logic [2:0] inflight_q;
	logic       acc;
	logic       dlv;

	imuhtc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	imuhtc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.sample  (sample),
		.vld_s2  (vld_s2),
		.pay_s2  (pay_s2),
		.s2_take (s2_take)
	);

	imuhtc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.vld_s2  (vld_s2),
		.pay_s2  (pay_s2),
		.s2_take (s2_take),
		.vld_s3  (vld_s3),
		.pay_s3  (pay_s3),
		.s3_take (s3_take)
	);

	imuhtc_integ u_integ (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.vld_s3  (vld_s3),
		.pay_s3  (pay_s3),
		.s3_take (s3_take),
		.result  (result)
	);

	// count items between acceptance and delivery
	assign acc = sample.valid && sample.ready;
	assign dlv = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (acc && !dlv) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (!acc && dlv) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	`IMUHTC_ASSERT_NOW(a_stall_full, !sample.ready, result.valid && !result.ready, "input stalled without a waiting result")
	`IMUHTC_ASSERT_NOW(a_pwm_match, result.valid && (result.pwm != '0), result.pwm == result.ctrl_out[OUT_W-1:8], "pwm disagrees with ctrl_out")
	`IMUHTC_ASSERT_NOW(a_depth, 1'b1, (result.valid == 1'b0 || inflight_q != '0) && inflight_q <= 3'd4, "item count out of bounds")
	`IMUHTC_ASSERT_NEXT(a_no_orphan, inflight_q == '0, !result.valid, "result without an accepted item")

endmodule
`default_nettype wire

>>> hw/rtl/imuhtc_cfg.sv
// Configuration register file with its write decode.
`timescale 1ns / 1ps
`default_nettype none
module imuhtc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [imuhtc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [imuhtc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output imuhtc_pkg::cfg_t                   cfg
);
	import imuhtc_pkg::*;

	cfg_t regs_q;

	assign cfg = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mode        <= MODE_RESET;
			regs_q.target_temp <= TARGET_RESET;
			regs_q.pwm_max     <= PWM_RESET;
			regs_q.prop_gain   <= GAIN_RESET;
			regs_q.stable_band <= BAND_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:        regs_q.mode        <= cfg_data[0];
				REG_TARGET:      regs_q.target_temp <= signed'(cfg_data[TGT_W-1:0]);
				REG_PWM_MAX:     regs_q.pwm_max     <= cfg_data[PWM_W-1:0];
				REG_PROP_GAIN:   regs_q.prop_gain   <= cfg_data[PWM_W-1:0];
				REG_STABLE_BAND: regs_q.stable_band <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/imuhtc_front.sv
// Input register, sample gating, update timer, min/max window and the shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module imuhtc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  imuhtc_pkg::cfg_t  cfg,
	imuhtc_in_if.sink         sample,
	output logic              vld_s2,
	output imuhtc_pkg::s2_t   pay_s2,
	input  logic              s2_take
);
	import imuhtc_pkg::*;

	logic                     vld_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic                     tvld_s1;
	logic [TS_W-1:0]          now_s1;
	logic                     busy_s1;
	logic                     heat_s1;

	logic [TS_W-1:0]          last_upd_q;
	logic [TS_W-1:0]          win_start_q;
	logic signed [TEMP_W-1:0] win_low_q;
	logic signed [TEMP_W-1:0] win_high_q;
	logic                     settled_q;

	logic                     adv2;
	logic                     ld1;
	logic                     fire;
	logic signed [TEMP_W-1:0] tgt_q;
	logic signed [ERR_W-1:0]  err;
	logic [ERR_W-1:0]         abs_err;
	logic                     near;
	logic                     gate_off;
	logic                     bad;
	logic [TS_W-1:0]          elapsed;
	logic                     due;
	logic [DT_W-1:0]          dt;
	logic [PWM_W-1:0]         opnd;
	logic signed [PROD_W-1:0] prod;
	logic signed [TEMP_W-1:0] low_n;
	logic signed [TEMP_W-1:0] high_n;
	logic signed [TEMP_W:0]   swing;
	logic                     win_due;
	logic                     settled_n;
	cls_t                     cls;
	logic                     stable;
	logic                     win_upd;

	assign adv2         = !vld_s2 || s2_take;
	assign ld1          = !vld_s1 || adv2;
	assign sample.ready = ld1;
	assign fire         = vld_s1 && adv2;

	assign tgt_q    = {cfg.target_temp, 8'h00};
	assign err      = ERR_W'(tgt_q) - ERR_W'(temp_s1);
	assign abs_err  = err[ERR_W-1] ? unsigned'(-err) : unsigned'(err);
	assign near     = abs_err <= ERR_W'(cfg.stable_band);
	assign gate_off = busy_s1 || !heat_s1;
	assign bad      = !tvld_s1 || (temp_s1 < TEMP_LOW_Q) || (temp_s1 > TEMP_HIGH_Q);

	// elapsed time wraps with the timestamp
	assign elapsed = now_s1 - last_upd_q;
	assign due     = elapsed >= PERIOD_MS;
	assign dt      = (elapsed > DT_CAP_MS) ? DT_CAP : elapsed[DT_W-1:0];

	// one multiplier: err * 2 * dt for PI mode, err * prop_gain for P mode
	assign opnd = cfg.mode ? cfg.prop_gain : PWM_W'({dt, 1'b0});
	assign prod = err * $signed({1'b0, opnd});

	assign low_n     = (temp_s1 < win_low_q) ? temp_s1 : win_low_q;
	assign high_n    = (temp_s1 > win_high_q) ? temp_s1 : win_high_q;
	assign swing     = (TEMP_W+1)'(high_n) - (TEMP_W+1)'(low_n);
	assign win_due   = (now_s1 - win_start_q) >= WINDOW_MS;
	assign settled_n = win_due ? (swing <= SWING_Q) : settled_q;

	always_comb begin
		priority if (gate_off) begin
			cls = CLS_OFF;
		end else if (bad) begin
			cls = CLS_BAD;
		end else if (cfg.mode) begin
			cls = CLS_RUN1;
		end else if (due) begin
			cls = CLS_RUN0;
		end else begin
			cls = CLS_HOLD;
		end
	end

	assign win_upd = (cls == CLS_RUN0) || (cls == CLS_HOLD);

	always_comb begin
		unique case (cls)
			CLS_RUN0, CLS_HOLD: stable = near && settled_n;
			CLS_RUN1:           stable = near;
			default:            stable = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld1) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && sample.valid) begin
			temp_s1 <= sample.temp;
			tvld_s1 <= sample.temp_valid;
			now_s1  <= sample.now_ms;
			busy_s1 <= sample.store_busy;
			heat_s1 <= sample.heat_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_upd_q  <= '0;
			win_start_q <= '0;
			win_low_q   <= WIN_LOW_RESET;
			win_high_q  <= WIN_HIGH_RESET;
			settled_q   <= 1'b0;
		end else if (fire) begin
			if (cls == CLS_RUN0) begin
				last_upd_q <= now_s1;
			end
			if (win_upd) begin
				// restart the window once it has run its length
				if (win_due) begin
					win_low_q   <= temp_s1;
					win_high_q  <= temp_s1;
					win_start_q <= now_s1;
					settled_q   <= settled_n;
				end else begin
					win_low_q  <= low_n;
					win_high_q <= high_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pay_s2.cls    <= cls;
			pay_s2.err    <= err;
			pay_s2.prod   <= prod;
			pay_s2.stable <= stable;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/imuhtc_div.sv
// Rounded division of the integral step by 1000, P term and clamped P-mode output.
`timescale 1ns / 1ps
`default_nettype none
module imuhtc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  imuhtc_pkg::cfg_t  cfg,
	input  logic              vld_s2,
	input  imuhtc_pkg::s2_t   pay_s2,
	output logic              s2_take,
	output logic              vld_s3,
	output imuhtc_pkg::s3_t   pay_s3,
	input  logic              s3_take
);
	import imuhtc_pkg::*;

	logic                     adv3;
	logic                     fire;
	logic signed [Y_W-1:0]    ysum;
	logic signed [Y_W-1:0]    yneg;
	logic                     neg;
	logic [MAG_W-1:0]         mag;
	logic [QP_W-1:0]          qprod;
	logic [Q_W-1:0]           q;
	logic signed [STEP_W-1:0] qs;
	logic signed [STEP_W-1:0] step;
	logic signed [P_W-1:0]    err_x;
	logic signed [P_W-1:0]    p;
	logic signed [O1_W-1:0]   o1w;
	logic [OUT_W-1:0]         pmax_q;
	logic [OUT_W-1:0]         o1;

	assign adv3    = !vld_s3 || s3_take;
	assign s2_take = adv3;
	assign fire    = vld_s2 && adv3;

	// floor((x + 500) / 1000); a negative sum divides its magnitude rounded up
	assign ysum  = $signed(pay_s2.prod[Y_W-1:0]) + ROUND_HALF;
	assign neg   = ysum[Y_W-1];
	assign yneg  = ROUND_UP - ysum;
	assign mag   = neg ? unsigned'(yneg[MAG_W-1:0]) : unsigned'(ysum[MAG_W-1:0]);
	assign qprod = QP_W'(mag[MAG_W-1:3]) * QP_W'(DIV_MAGIC);
	assign q     = qprod[DIV_SHIFT+Q_W-1:DIV_SHIFT];
	assign qs    = $signed(STEP_W'(q));
	assign step  = neg ? -qs : qs;

	assign err_x = P_W'(pay_s2.err);
	assign p     = (err_x <<< 4) + (err_x <<< 2);

	assign o1w    = $signed(pay_s2.prod[PROD_W-1:8]);
	assign pmax_q = {cfg.pwm_max, 8'h00};

	always_comb begin
		priority if (o1w[O1_W-1]) begin
			o1 = '0;
		end else if (o1w > $signed(O1_W'(pmax_q))) begin
			o1 = pmax_q;
		end else begin
			o1 = o1w[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pay_s3.cls     <= pay_s2.cls;
			pay_s3.step    <= step;
			pay_s3.p       <= p;
			pay_s3.o1      <= o1;
			pay_s3.err_le0 <= pay_s2.err[ERR_W-1] || (pay_s2.err == '0);
			pay_s3.ovh     <= pay_s2.err <= OVERHEAT_ERR;
			pay_s3.stable  <= pay_s2.stable;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/imuhtc_integ.sv
// Integrator with conditional integration, output clamp, held outputs and result register.
`timescale 1ns / 1ps
`default_nettype none
module imuhtc_integ (
	input  logic              clk,
	input  logic              arst_n,
	input  imuhtc_pkg::cfg_t  cfg,
	input  logic              vld_s3,
	input  imuhtc_pkg::s3_t   pay_s3,
	output logic              s3_take,
	imuhtc_out_if.source      result
);
	import imuhtc_pkg::*;

	logic                     vld_out_q;
	logic [INTEG_W-1:0]       integ_q;
	logic [OUT_W-1:0]         held_out_q;
	logic [PWM_W-1:0]         held_pwm_q;
	logic                     stable_q;

	logic                     adv_o;
	logic                     fire;
	logic [7:0]               lim_pwm;
	logic [INTEG_W-1:0]       limit;
	logic signed [C_W-1:0]    cand_raw;
	logic signed [C_W-1:0]    lim_c;
	logic [INTEG_W-1:0]       cand;
	logic signed [P_W:0]      limw;
	logic signed [P_W:0]      sum_pc;
	logic                     take;
	logic [INTEG_W-1:0]       integ_n;
	logic signed [P_W:0]      sum_po;
	logic [INTEG_W-1:0]       o0;
	logic [INTEG_W-1:0]       integ_f;
	logic [INTEG_W-1:0]       o0f;

	assign adv_o   = !vld_out_q || result.ready;
	assign s3_take = adv_o;
	assign fire    = vld_s3 && adv_o;

	assign lim_pwm = (cfg.pwm_max < LIMIT_CAP) ? cfg.pwm_max[7:0] : LIMIT_CAP[7:0];
	assign limit   = {lim_pwm, 8'h00};
	assign lim_c   = $signed(C_W'(limit));
	assign limw    = $signed((P_W+1)'(limit));

	assign cand_raw = $signed(C_W'(integ_q)) + C_W'(pay_s3.step);

	always_comb begin
		priority if (cand_raw[C_W-1]) begin
			cand = '0;
		end else if (cand_raw > lim_c) begin
			cand = limit;
		end else begin
			cand = cand_raw[INTEG_W-1:0];
		end
	end

	// integrate only while cooling is asked for or the output is not saturated
	assign sum_pc  = (P_W+1)'(pay_s3.p) + $signed((P_W+1)'(cand));
	assign take    = pay_s3.err_le0 || (sum_pc < limw);
	assign integ_n = take ? cand : integ_q;
	assign sum_po  = (P_W+1)'(pay_s3.p) + $signed((P_W+1)'(integ_n));

	always_comb begin
		priority if (sum_po[P_W]) begin
			o0 = '0;
		end else if (sum_po > limw) begin
			o0 = limit;
		end else begin
			o0 = sum_po[INTEG_W-1:0];
		end
	end

	// overheat drops both output and integral
	assign integ_f = pay_s3.ovh ? '0 : integ_n;
	assign o0f     = pay_s3.ovh ? '0 : o0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q  <= 1'b0;
			integ_q    <= '0;
			held_out_q <= '0;
			held_pwm_q <= '0;
			stable_q   <= 1'b0;
		end else begin
			if (adv_o) begin
				vld_out_q <= vld_s3;
			end
			if (fire) begin
				stable_q <= pay_s3.stable;
				unique case (pay_s3.cls)
					CLS_OFF: begin
						held_pwm_q <= '0;
					end
					CLS_BAD: begin
						held_pwm_q <= '0;
						held_out_q <= '0;
					end
					CLS_HOLD: begin
					end
					CLS_RUN0: begin
						integ_q    <= integ_f;
						held_out_q <= OUT_W'(o0f);
						held_pwm_q <= PWM_W'(o0f[INTEG_W-1:8]);
					end
					CLS_RUN1: begin
						held_out_q <= pay_s3.o1;
						held_pwm_q <= pay_s3.o1[OUT_W-1:8];
					end
					default: ;
				endcase
			end
		end
	end

	assign result.valid    = vld_out_q;
	assign result.pwm      = held_pwm_q;
	assign result.ctrl_out = held_out_q;
	assign result.stable   = stable_q;
endmodule
`default_nettype wire

>>> tb/imuhtc_tb_pkg.sv
// Controller mode codes shared by the heater controller testbench files.
`timescale 1ns / 1ps
package imuhtc_tb_pkg;

	localparam logic [0:0] MODE_PI   = 1'b0;
	localparam logic [0:0] MODE_PROP = 1'b1;

endpackage

>>> tb/imuhtc_heater_scoreboard.sv
// Scoreboard for the heater controller: predicts each heater command and checks the results.
`timescale 1ns / 1ps
module imuhtc_heater_scoreboard
	import imuhtc_pkg::*;
	import imuhtc_tb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [TEMP_W-1:0] in_temp,
	input  logic                     in_temp_valid,
	input  logic [TS_W-1:0]          in_now_ms,
	input  logic                     in_store_busy,
	input  logic                     in_heat_enable,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [PWM_W-1:0]         out_pwm,
	input  logic [OUT_W-1:0]         out_ctrl_out,
	input  logic                     out_stable,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output int                       fail_count,
	output int                       pending
);

	typedef struct packed {
		logic [PWM_W-1:0] pwm;
		logic [OUT_W-1:0] ctrl_out;
		logic             stable;
	} heater_cmd_t;

	heater_cmd_t      heater_cmd_q[$];
	cfg_t             cfg;
	logic [TS_W-1:0]  last_upd_ms;
	logic [INTEG_W-1:0] integ_acc;
	logic [OUT_W-1:0] held_out;
	logic [PWM_W-1:0] held_pwm;
	logic [TS_W-1:0]  win_start_ms;
	int               win_low;
	int               win_high;
	logic             settled;

	function automatic longint floor_div(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic predict_heater_cmd(
		input  logic signed [TEMP_W-1:0] t,
		input  logic                     tv,
		input  logic [TS_W-1:0]          now,
		input  logic                     busy,
		input  logic                     en,
		output heater_cmd_t              cmd
	);
		longint          tq;
		longint          tgt_q;
		longint          err;
		longint          abs_err;
		longint          lim;
		longint          p;
		longint          cand;
		longint          o;
		logic [TS_W-1:0] elapsed;
		logic [TS_W-1:0] dt;
		logic [TS_W-1:0] win_age;
		logic            near;
		near = 1'b0;
		tq = t;
		if (busy || !en) begin
			held_pwm = '0;
		end else if (!tv || tq < longint'(TEMP_LOW_Q) || tq > longint'(TEMP_HIGH_Q)) begin
			held_pwm = '0;
			held_out = '0;
		end else begin
			tgt_q = longint'(cfg.target_temp) * 256;
			err = tgt_q - tq;
			abs_err = (err < 0) ? -err : err;
			near = (abs_err <= longint'(cfg.stable_band));
			if (cfg.mode == MODE_PI) begin
				elapsed = now - last_upd_ms;
				if (elapsed >= PERIOD_MS) begin
					dt = (elapsed > DT_CAP_MS) ? DT_CAP_MS : elapsed;
					lim = longint'((cfg.pwm_max < LIMIT_CAP) ? cfg.pwm_max : LIMIT_CAP) * 256;
					p = err * 20;
					last_upd_ms = now;
					cand = longint'(integ_acc) + floor_div(err * 2 * longint'(dt) + 500, 1000);
					cand = clamp(cand, 0, lim);
					// conditional integration: hold the integral while pushing into the limit
					if (err <= 0 || p + cand < lim)
						integ_acc = cand[INTEG_W-1:0];
					o = clamp(p + longint'(integ_acc), 0, lim);
					if (tq >= tgt_q + 256) begin
						o = 0;
						integ_acc = '0;
					end
					held_out = o[OUT_W-1:0];
					held_pwm = o[OUT_W-1:8];
				end
				if (tq < win_low)
					win_low = int'(tq);
				if (tq > win_high)
					win_high = int'(tq);
				win_age = now - win_start_ms;
				if (win_age >= WINDOW_MS) begin
					settled = (win_high - win_low <= 128);
					win_low = int'(tq);
					win_high = int'(tq);
					win_start_ms = now;
				end
				near = near && settled;
			end else begin
				o = floor_div(err * longint'(cfg.prop_gain), 256);
				o = clamp(o, 0, longint'(cfg.pwm_max) * 256);
				held_out = o[OUT_W-1:0];
				held_pwm = o[OUT_W-1:8];
			end
		end
		cmd.pwm = held_pwm;
		cmd.ctrl_out = held_out;
		cmd.stable = near;
	endtask

	always @(posedge clk or negedge arst_n) begin
		heater_cmd_t cmd;
		heater_cmd_t want;
		if (!arst_n) begin
			cfg.mode = MODE_RESET;
			cfg.target_temp = TARGET_RESET;
			cfg.pwm_max = PWM_RESET;
			cfg.prop_gain = GAIN_RESET;
			cfg.stable_band = BAND_RESET;
			last_upd_ms = '0;
			integ_acc = '0;
			held_out = '0;
			held_pwm = '0;
			win_start_ms = '0;
			win_low = int'(WIN_LOW_RESET);
			win_high = int'(WIN_HIGH_RESET);
			settled = 1'b0;
			heater_cmd_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_MODE:        cfg.mode = cfg_data[0];
					REG_TARGET:      cfg.target_temp = cfg_data[TGT_W-1:0];
					REG_PWM_MAX:     cfg.pwm_max = cfg_data;
					REG_PROP_GAIN:   cfg.prop_gain = cfg_data;
					REG_STABLE_BAND: cfg.stable_band = cfg_data[BAND_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				predict_heater_cmd(in_temp, in_temp_valid, in_now_ms, in_store_busy,
					in_heat_enable, cmd);
				heater_cmd_q.push_back(cmd);
			end
			if (out_valid && out_ready) begin
				if (heater_cmd_q.size() == 0) begin
					$error("result with no sample waiting: pwm %0d ctrl_out %0d stable %0d",
						out_pwm, out_ctrl_out, out_stable);
					fail_count++;
				end else begin
					want = heater_cmd_q.pop_front();
					if (out_pwm !== want.pwm) begin
						$error("pwm: expected %0d, actual %0d", want.pwm, out_pwm);
						fail_count++;
					end
					if (out_ctrl_out !== want.ctrl_out) begin
						$error("ctrl_out: expected %0d, actual %0d", want.ctrl_out, out_ctrl_out);
						fail_count++;
					end
					if (out_stable !== want.stable) begin
						$error("stable: expected %0d, actual %0d", want.stable, out_stable);
						fail_count++;
					end
				end
			end
			pending = heater_cmd_q.size();
		end
	end

endmodule

>>> tb/tb_imu_heater_temperature_controller_core.sv
// Testbench top for the heater controller core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_imu_heater_temperature_controller_core;
	import imuhtc_pkg::*;
	import imuhtc_tb_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_t;

	localparam int QUIET_LIMIT = 5000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;
	int                    send_idle_pct;
	int                    stall_pct;
	int                    quiet_cycles;
	logic [TS_W-1:0]       clock_ms;

	imuhtc_in_if  sample ();
	imuhtc_out_if result ();

	imu_heater_temperature_controller_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	imuhtc_heater_scoreboard u_score (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (sample.valid),
		.in_ready       (sample.ready),
		.in_temp        (sample.temp),
		.in_temp_valid  (sample.temp_valid),
		.in_now_ms      (sample.now_ms),
		.in_store_busy  (sample.store_busy),
		.in_heat_enable (sample.heat_enable),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.out_pwm        (result.pwm),
		.out_ctrl_out   (result.ctrl_out),
		.out_stable     (result.stable),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		result.ready = ($urandom_range(99) >= stall_pct);
	end

	// end the run if neither channel moves an item for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample.valid && sample.ready) || (result.valid && result.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_imu_heater_temperature_controller_core: FAIL");
				$finish;
			end
		end
	end

	task automatic send_sample(
		input logic signed [TEMP_W-1:0] t,
		input logic                     tv,
		input logic [TS_W-1:0]          now,
		input logic                     busy,
		input logic                     en
	);
		while ($urandom_range(99) < send_idle_pct) begin
			sample.valid = 1'b0;
			@(negedge clk);
		end
		sample.valid = 1'b1;
		sample.temp = t;
		sample.temp_valid = tv;
		sample.now_ms = now;
		sample.store_busy = busy;
		sample.heat_enable = en;
		do
			@(posedge clk);
		while (!sample.ready);
		@(negedge clk);
	endtask

	// hold the sender until every outstanding result has come back
	task automatic drain_results();
		sample.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_phase(
		input logic [0:0]               mode,
		input logic signed [TGT_W-1:0]  tgt,
		input logic [PWM_W-1:0]         pmax,
		input logic [PWM_W-1:0]         gain,
		input logic [BAND_W-1:0]        band,
		input int                       center_c,
		input int                       n,
		input idle_t                    idle
	);
		int       burst;
		int       t_i;
		int       center_q;
		logic     tv;
		logic     busy;
		logic     en;
		logic [TS_W-1:0] step;
		burst = 0;
		drain_results();
		write_reg(REG_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
		write_reg(REG_TARGET, {8'h00, tgt});
		write_reg(REG_PWM_MAX, pmax);
		write_reg(REG_PROP_GAIN, gain);
		write_reg(REG_STABLE_BAND, {4'h0, band});
		case (idle)
			IDLE_NONE:  begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SEND:  begin send_idle_pct = 60; stall_pct = 0;  end
			IDLE_STALL: begin send_idle_pct = 0;  stall_pct = 60; end
			default:    begin send_idle_pct = 10; stall_pct = 10; end
		endcase
		center_q = center_c * 256;
		for (int i = 0; i < n; i++) begin
			if (i % 24 == 0)
				burst = $urandom_range(9);
			tv = ($urandom_range(99) >= 3);
			busy = ($urandom_range(99) < 3);
			en = ($urandom_range(99) >= 3);
			if (burst <= 4) begin
				// settling run: small swing so the stability window can close
				t_i = center_q + int'($urandom_range(120)) - 60;
				step = $urandom_range(160, 60);
			end else if (burst <= 7) begin
				t_i = center_q + int'($urandom_range(5120)) - 2560;
				step = $urandom_range(300);
			end else begin
				t_i = int'($urandom_range(65535)) - 32768;
				tv = 1'($urandom_range(1));
				busy = 1'($urandom_range(1));
				en = 1'($urandom_range(1));
				step = ($urandom_range(3) == 0) ? $urandom : $urandom_range(500);
			end
			clock_ms = clock_ms + step;
			send_sample(t_i[TEMP_W-1:0], tv, clock_ms, busy, en);
		end
	endtask

	initial begin
		int rnd_tgt;
		sample.valid = 1'b0;
		sample.temp = '0;
		sample.temp_valid = 1'b0;
		sample.now_ms = '0;
		sample.store_busy = 1'b0;
		sample.heat_enable = 1'b0;
		result.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		clock_ms = '0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: target 40 C, PI mode
		send_sample(16'sd10240, 1'b1, 32'd0, 1'b0, 1'b1);
		send_sample(16'sd10240, 1'b1, 32'd100, 1'b0, 1'b1);
		send_sample(16'sd5120, 1'b1, 32'd150, 1'b0, 1'b1);
		send_sample(16'sd5120, 1'b1, 32'd250, 1'b0, 1'b1);
		send_sample(16'sd5120, 1'b1, 32'd9000, 1'b0, 1'b1);
		send_sample(16'sd5120, 1'b1, 32'd9100, 1'b1, 1'b1);
		send_sample(16'sd5120, 1'b1, 32'd9200, 1'b0, 1'b0);
		send_sample(16'sd5120, 1'b1, 32'd9300, 1'b1, 1'b0);
		send_sample(16'sd5120, 1'b0, 32'd9400, 1'b0, 1'b1);
		send_sample(-16'sd10240, 1'b1, 32'd9500, 1'b0, 1'b1);
		send_sample(-16'sd10241, 1'b1, 32'd9600, 1'b0, 1'b1);
		send_sample(16'sd15360, 1'b1, 32'd9700, 1'b0, 1'b1);
		send_sample(16'sd15361, 1'b1, 32'd9800, 1'b0, 1'b1);
		send_sample(16'sh8000, 1'b1, 32'd9900, 1'b0, 1'b1);
		send_sample(16'sh7FFF, 1'b1, 32'd10000, 1'b0, 1'b1);
		send_sample(16'sd10496, 1'b1, 32'd10100, 1'b0, 1'b1);
		send_sample(16'sd10495, 1'b1, 32'd10200, 1'b0, 1'b1);
		for (int k = 0; k < 6; k++)
			send_sample(16'sd10250, 1'b1, 32'd10700 + 32'(k * 500), 1'b0, 1'b1);
		// timestamp wrap
		send_sample(16'sd10250, 1'b1, 32'hFFFF_FF00, 1'b0, 1'b1);
		send_sample(16'sd10250, 1'b1, 32'h0000_0010, 1'b0, 1'b1);
		clock_ms = 32'h0000_0010;

		run_phase(MODE_PI, 8'sd40, 16'd200, 16'd2560, 12'd256, 40, 100, IDLE_NONE);
		run_phase(MODE_PI, 8'sd30, 16'hFFFF, 16'd0, 12'd2560, 28, 100, IDLE_SEND);
		// lowered limit with the integral carried over
		run_phase(MODE_PI, 8'sd30, 16'd40, 16'd0, 12'd0, 29, 80, IDLE_STALL);
		run_phase(MODE_PI, -8'sd40, 16'd0, 16'hFFFF, 12'd128, -39, 60, IDLE_BOTH);
		run_phase(MODE_PI, 8'sd127, 16'hFFFF, 16'd1, 12'd2560, 58, 40, IDLE_NONE);
		run_phase(MODE_PROP, 8'sd45, 16'hFFFF, 16'hFFFF, 12'd2560, 43, 90, IDLE_SEND);
		run_phase(MODE_PROP, -8'sd128, 16'hFFFF, 16'hFFFF, 12'd0, -38, 40, IDLE_STALL);
		run_phase(MODE_PROP, 8'sd20, 16'd0, 16'd2560, 12'd1000, 19, 50, IDLE_BOTH);
		run_phase(MODE_PROP, 8'sd50, 16'd300, 16'd0, 12'd300, 48, 40, IDLE_NONE);
		clock_ms = 32'hFFFF_F000;
		run_phase(MODE_PI, 8'sd35, 16'd150, 16'd2560, 12'd64, 35, 110, IDLE_STALL);
		rnd_tgt = $urandom_range(50, 20);
		run_phase(MODE_PI, 8'(rnd_tgt), 16'($urandom_range(65535)), 16'($urandom_range(65535)),
			12'($urandom_range(2560)), rnd_tgt, 100, IDLE_BOTH);
		run_phase(MODE_PI, 8'sd40, 16'd200, 16'd2560, 12'd256, 40, 100, IDLE_SEND);
		rnd_tgt = $urandom_range(50, 20);
		run_phase(MODE_PROP, 8'(rnd_tgt), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 12'($urandom_range(2560)), rnd_tgt - 1, 60, IDLE_NONE);

		drain_results();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("tb_imu_heater_temperature_controller_core: PASS");
		else
			$display("tb_imu_heater_temperature_controller_core: FAIL");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/imuhtc_pkg.sv
hw/rtl/imuhtc_in_if.sv
hw/rtl/imuhtc_out_if.sv
hw/rtl/imuhtc_cfg.sv
hw/rtl/imuhtc_front.sv
hw/rtl/imuhtc_div.sv
hw/rtl/imuhtc_integ.sv
hw/rtl/imu_heater_temperature_controller_core.sv
tb/imuhtc_tb_pkg.sv
tb/imuhtc_heater_scoreboard.sv
tb/tb_imu_heater_temperature_controller_core.sv
